>>> rtl/core/lfs_pkg.sv
package lfs_pkg;

    localparam int unsigned POS_W   = 13;
    localparam int unsigned THR_W   = 12;
    localparam int unsigned SPEED_W = 12;
    localparam int unsigned GAIN_W  = 8;
    localparam int unsigned DUTY_W  = 16;
    localparam int unsigned HOLD_W  = 9;
    localparam int unsigned CFG_A_W = 3;
    localparam int unsigned CFG_D_W = 12;

    localparam logic signed [POS_W-1:0] LOST_CODE   = 13'sd1000;
    localparam logic [SPEED_W-1:0]      SLOW_DELTA  = 12'd10;
    localparam logic [HOLD_W-1:0]       SHARP_HOLD  = 9'd400;
    localparam logic [HOLD_W-1:0]       RECENT_HOLD = 9'd200;
    localparam logic [DUTY_W-1:0]       DUTY_MAX    = 16'hFFFF;

    localparam logic [CFG_A_W-1:0] REG_TURN_THR  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_HARD_THR  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_SHARP_THR = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_BASE_SPD  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_GAIN      = 3'd4;

    typedef enum logic [3:0] {
        ST_CENTERED    = 4'd0,
        ST_RIGHT       = 4'd1,
        ST_HARD_RIGHT  = 4'd2,
        ST_SHARP_RIGHT = 4'd3,
        ST_LEFT        = 4'd4,
        ST_HARD_LEFT   = 4'd5,
        ST_SHARP_LEFT  = 4'd6,
        ST_RECENTERED  = 4'd7,
        ST_LOST        = 4'd8
    } drive_state_t;

    typedef struct packed {
        logic                left_reverse;
        logic                right_reverse;
        logic [DUTY_W-1:0]   left_duty;
        logic [DUTY_W-1:0]   right_duty;
        logic                led_left;
        logic                led_right;
        logic                led_back;
        logic [HOLD_W-1:0]   hold_ms;
    } drive_out_t;

endpackage

>>> rtl/core/line_follow_steering_fsm.sv
// Line-follower steering controller. Each input beat carries one signed line
// position; each output beat carries the new steering state with its wheel
// directions, saturated wheel duties, lamps and hold time. The block is a
// two-stage pipeline (input register, then state update and result register)
// that takes a new beat every cycle unless out_ready stalls the output. The
// steering state advances in the second stage, which keeps back-to-back
// beats exact. Registers are to be written through the cfg port only while no
// beat is in flight; the user must keep to this, as the block does not enforce it.
module line_follow_steering_fsm
    import lfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_wr_en,
    input  logic [CFG_A_W-1:0]       cfg_addr,
    input  logic [CFG_D_W-1:0]       cfg_wdata,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [POS_W-1:0]  line_position,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [3:0]               drive_state,
    output logic                     left_reverse,
    output logic                     right_reverse,
    output logic [DUTY_W-1:0]        left_duty,
    output logic [DUTY_W-1:0]        right_duty,
    output logic                     led_left,
    output logic                     led_right,
    output logic                     led_back,
    output logic [HOLD_W-1:0]        hold_ms
);

    logic [THR_W-1:0]         turn_thr_reg;
    logic [THR_W-1:0]         hard_thr_reg;
    logic [THR_W-1:0]         sharp_thr_reg;
    logic [SPEED_W-1:0]       base_speed_reg;
    logic [GAIN_W-1:0]        gain_reg;

    logic                     s1_valid_reg;
    logic signed [POS_W-1:0]  s1_pos_reg;
    logic                     out_valid_reg;
    drive_state_t             state_reg;
    drive_state_t             state_next;
    drive_out_t               drive_reg;
    drive_out_t               drive_next;

    logic                     s2_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_thr_reg   <= 12'd48;
            hard_thr_reg   <= 12'd200;
            sharp_thr_reg  <= 12'd600;
            base_speed_reg <= 12'd30;
            gain_reg       <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TURN_THR:  turn_thr_reg   <= cfg_wdata[THR_W-1:0];
                REG_HARD_THR:  hard_thr_reg   <= cfg_wdata[THR_W-1:0];
                REG_SHARP_THR: sharp_thr_reg  <= cfg_wdata[THR_W-1:0];
                REG_BASE_SPD:  base_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_GAIN:      gain_reg       <= cfg_wdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    assign s2_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_pos_reg <= line_position;
        end
    end

    lfs_next_state u_next_state (
        .cur_state     (state_reg),
        .line_position (s1_pos_reg),
        .band_thr      (turn_thr_reg),
        .hard_thr      (hard_thr_reg),
        .sharp_thr     (sharp_thr_reg),
        .next_state    (state_next)
    );

    lfs_drive_decode u_drive_decode (
        .drive_state (state_next),
        .base_speed  (base_speed_reg),
        .speed_gain  (gain_reg),
        .drive       (drive_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CENTERED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
            begin
                state_reg <= state_next;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_state   = state_reg;
    assign left_reverse  = drive_reg.left_reverse;
    assign right_reverse = drive_reg.right_reverse;
    assign left_duty     = drive_reg.left_duty;
    assign right_duty    = drive_reg.right_duty;
    assign led_left      = drive_reg.led_left;
    assign led_right     = drive_reg.led_right;
    assign led_back      = drive_reg.led_back;
    assign hold_ms       = drive_reg.hold_ms;

endmodule

>>> rtl/core/lfs_next_state.sv
module lfs_next_state
    import lfs_pkg::*;
(
    input  drive_state_t                cur_state,
    input  logic signed [POS_W-1:0]     line_position,
    input  logic [THR_W-1:0]            band_thr,
    input  logic [THR_W-1:0]            hard_thr,
    input  logic [THR_W-1:0]            sharp_thr,
    output drive_state_t                next_state
);

    logic signed [POS_W:0] pos;
    logic signed [POS_W:0] t_pos;
    logic signed [POS_W:0] h_pos;
    logic signed [POS_W:0] s_pos;
    logic                  full;
    logic                  centered;

    assign pos   = {line_position[POS_W-1], line_position};
    assign t_pos = $signed({2'b00, band_thr});
    assign h_pos = $signed({2'b00, hard_thr});
    assign s_pos = $signed({2'b00, sharp_thr});

    assign full = (cur_state == ST_CENTERED) || (cur_state == ST_RIGHT)
               || (cur_state == ST_LEFT);
    assign centered = (pos >= -t_pos) && (pos <= t_pos);

    always_comb
    begin
        priority if (centered)
        begin
            next_state = ST_CENTERED;
        end
        else if (cur_state > ST_RECENTERED)
        begin
            next_state = ST_LOST;
        end
        else if (line_position == LOST_CODE)
        begin
            unique case (cur_state)
                ST_RIGHT:       next_state = ST_HARD_RIGHT;
                ST_HARD_RIGHT:  next_state = ST_SHARP_RIGHT;
                ST_SHARP_RIGHT: next_state = ST_RECENTERED;
                ST_LEFT:        next_state = ST_HARD_LEFT;
                ST_HARD_LEFT:   next_state = ST_SHARP_LEFT;
                ST_SHARP_LEFT:  next_state = ST_RECENTERED;
                default:        next_state = ST_LOST;
            endcase
        end
        else if (pos > t_pos)
        begin
            priority if (pos <= h_pos)
            begin
                next_state = ST_RIGHT;
            end
            else if (!full || (pos <= s_pos))
            begin
                next_state = ST_HARD_RIGHT;
            end
            else
            begin
                next_state = ST_SHARP_RIGHT;
            end
        end
        else
        begin
            priority if (pos >= -h_pos)
            begin
                next_state = ST_LEFT;
            end
            else if (!full || (pos >= -s_pos))
            begin
                next_state = ST_HARD_LEFT;
            end
            else
            begin
                next_state = ST_SHARP_LEFT;
            end
        end
    end

endmodule

>>> rtl/core/lfs_drive_decode.sv
module lfs_drive_decode
    import lfs_pkg::*;
(
    input  drive_state_t          drive_state,
    input  logic [SPEED_W-1:0]    base_speed,
    input  logic [GAIN_W-1:0]     speed_gain,
    output drive_out_t            drive
);

    localparam int unsigned PROD_W = SPEED_W + GAIN_W;

    logic [SPEED_W-1:0] slow;
    logic [SPEED_W-1:0] half;
    logic [SPEED_W-1:0] lspd;
    logic [SPEED_W-1:0] rspd;
    logic [PROD_W-1:0]  lprod;
    logic [PROD_W-1:0]  rprod;
    logic [DUTY_W-1:0]  lduty;
    logic [DUTY_W-1:0]  rduty;
    logic               lrev;
    logic               rrev;
    logic               lled;
    logic               rled;
    logic               bled;
    logic [HOLD_W-1:0]  hold;

    assign slow = (base_speed > SLOW_DELTA) ? (base_speed - SLOW_DELTA) : '0;
    assign half = base_speed >> 1;

    always_comb
    begin
        lspd = base_speed;
        rspd = base_speed;
        lrev = 1'b0;
        rrev = 1'b0;
        lled = 1'b0;
        rled = 1'b0;
        bled = 1'b0;
        hold = '0;
        unique case (drive_state)
            ST_CENTERED:
            begin
                lled = 1'b1;
                rled = 1'b1;
            end
            ST_RIGHT:
            begin
                rspd = slow;
                rled = 1'b1;
            end
            ST_HARD_RIGHT:
            begin
                rspd = half;
                rrev = 1'b1;
                rled = 1'b1;
            end
            ST_SHARP_RIGHT:
            begin
                rrev = 1'b1;
                rled = 1'b1;
                hold = SHARP_HOLD;
            end
            ST_LEFT:
            begin
                lspd = slow;
                lled = 1'b1;
            end
            ST_HARD_LEFT:
            begin
                lspd = half;
                lrev = 1'b1;
                lled = 1'b1;
            end
            ST_SHARP_LEFT:
            begin
                lrev = 1'b1;
                lled = 1'b1;
                hold = SHARP_HOLD;
            end
            ST_RECENTERED:
            begin
                lled = 1'b1;
                rled = 1'b1;
                hold = RECENT_HOLD;
            end
            default:
            begin
                lspd = '0;
                rspd = '0;
                bled = 1'b1;
            end
        endcase
    end

    assign lprod = PROD_W'(lspd) * PROD_W'(speed_gain);
    assign rprod = PROD_W'(rspd) * PROD_W'(speed_gain);

    assign lduty = (lprod > PROD_W'(DUTY_MAX)) ? DUTY_MAX : lprod[DUTY_W-1:0];
    assign rduty = (rprod > PROD_W'(DUTY_MAX)) ? DUTY_MAX : rprod[DUTY_W-1:0];

    assign drive = {lrev, rrev, lduty, rduty, lled, rled, bled, hold};

endmodule

>>> sim/line_follow_steering_fsm_tb.sv
module line_follow_steering_fsm_tb;
    import lfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [3:0] state;
        drive_out_t outs;
    } drive_beat_t;

    localparam logic [CFG_A_W-1:0] REG_SPARE = 3'd7;

    localparam int DIRECTED_POS [25] = '{
        4095, 700, 0, 48, 49, 200, 201, int'(LOST_CODE), int'(LOST_CODE),
        int'(LOST_CODE), -4096, -48, -49, -201, -601, int'(LOST_CODE),
        int'(LOST_CODE), -700, 0, -601, int'(LOST_CODE), int'(LOST_CODE),
        int'(LOST_CODE), 600, -1
    };

    class steering_checker;
        int            turn_thr;
        int            hard_thr;
        int            sharp_thr;
        int unsigned   base_spd;
        int unsigned   gain;
        drive_state_t  cur_state;
        drive_beat_t   pending_drives[$];
        int unsigned   errors;

        function new();
            turn_thr  = 48;
            hard_thr  = 200;
            sharp_thr = 600;
            base_spd  = 30;
            gain      = 1;
            cur_state = ST_CENTERED;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
            case (idx)
                REG_TURN_THR:  turn_thr  = int'(data[THR_W-1:0]);
                REG_HARD_THR:  hard_thr  = int'(data[THR_W-1:0]);
                REG_SHARP_THR: sharp_thr = int'(data[THR_W-1:0]);
                REG_BASE_SPD:  base_spd  = data[SPEED_W-1:0];
                REG_GAIN:      gain      = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function drive_state_t steer(drive_state_t cur, int p);
            bit full;
            full = (cur == ST_CENTERED) || (cur == ST_RIGHT) || (cur == ST_LEFT);
            if (p >= -turn_thr && p <= turn_thr)
                return ST_CENTERED;
            if (cur == ST_LOST)
                return ST_LOST;
            if (p == int'(LOST_CODE))
            begin
                case (cur)
                    ST_RIGHT:       return ST_HARD_RIGHT;
                    ST_HARD_RIGHT:  return ST_SHARP_RIGHT;
                    ST_SHARP_RIGHT: return ST_RECENTERED;
                    ST_LEFT:        return ST_HARD_LEFT;
                    ST_HARD_LEFT:   return ST_SHARP_LEFT;
                    ST_SHARP_LEFT:  return ST_RECENTERED;
                    default:        return ST_LOST;
                endcase
            end
            if (p > turn_thr)
            begin
                if (p <= hard_thr)
                    return ST_RIGHT;
                if (!full || p <= sharp_thr)
                    return ST_HARD_RIGHT;
                return ST_SHARP_RIGHT;
            end
            if (p >= -hard_thr)
                return ST_LEFT;
            if (!full || p >= -sharp_thr)
                return ST_HARD_LEFT;
            return ST_SHARP_LEFT;
        endfunction

        function logic [DUTY_W-1:0] scale_duty(int unsigned speed);
            int unsigned prod;
            prod = speed * gain;
            return (prod > int'(DUTY_MAX)) ? DUTY_MAX : prod[DUTY_W-1:0];
        endfunction

        function void note_position(pos_t pos);
            drive_beat_t  want;
            drive_state_t nxt;
            int           p;
            int unsigned  sp;
            int unsigned  slow;
            int unsigned  half;
            int unsigned  ls;
            int unsigned  rs;
            p    = pos;
            sp   = base_spd;
            slow = (sp > SLOW_DELTA) ? sp - SLOW_DELTA : 0;
            half = sp / 2;
            ls   = sp;
            rs   = sp;
            want = '0;
            nxt  = steer(cur_state, p);
            cur_state  = nxt;
            want.state = nxt;
            case (nxt)
                ST_CENTERED:
                begin
                    want.outs.led_left  = 1'b1;
                    want.outs.led_right = 1'b1;
                end
                ST_RIGHT:
                begin
                    rs = slow;
                    want.outs.led_right = 1'b1;
                end
                ST_HARD_RIGHT:
                begin
                    rs = half;
                    want.outs.right_reverse = 1'b1;
                    want.outs.led_right     = 1'b1;
                end
                ST_SHARP_RIGHT:
                begin
                    want.outs.right_reverse = 1'b1;
                    want.outs.led_right     = 1'b1;
                    want.outs.hold_ms       = SHARP_HOLD;
                end
                ST_LEFT:
                begin
                    ls = slow;
                    want.outs.led_left = 1'b1;
                end
                ST_HARD_LEFT:
                begin
                    ls = half;
                    want.outs.left_reverse = 1'b1;
                    want.outs.led_left     = 1'b1;
                end
                ST_SHARP_LEFT:
                begin
                    want.outs.left_reverse = 1'b1;
                    want.outs.led_left     = 1'b1;
                    want.outs.hold_ms      = SHARP_HOLD;
                end
                ST_RECENTERED:
                begin
                    want.outs.led_left  = 1'b1;
                    want.outs.led_right = 1'b1;
                    want.outs.hold_ms   = RECENT_HOLD;
                end
                default:
                begin
                    ls = 0;
                    rs = 0;
                    want.outs.led_back = 1'b1;
                end
            endcase
            want.outs.left_duty  = scale_duty(ls);
            want.outs.right_duty = scale_duty(rs);
            pending_drives.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            end
        endfunction

        function void check_drive(drive_beat_t got);
            drive_beat_t want;
            if (pending_drives.size() == 0)
            begin
                errors++;
                $display("%0t: drive beat with no pending position, expected none, got state %0d",
                         $time, got.state);
                return;
            end
            want = pending_drives.pop_front();
            compare_field("drive_state",   want.state,              got.state);
            compare_field("left_reverse",  want.outs.left_reverse,  got.outs.left_reverse);
            compare_field("right_reverse", want.outs.right_reverse, got.outs.right_reverse);
            compare_field("left_duty",     want.outs.left_duty,     got.outs.left_duty);
            compare_field("right_duty",    want.outs.right_duty,    got.outs.right_duty);
            compare_field("led_left",      want.outs.led_left,      got.outs.led_left);
            compare_field("led_right",     want.outs.led_right,     got.outs.led_right);
            compare_field("led_back",      want.outs.led_back,      got.outs.led_back);
            compare_field("hold_ms",       want.outs.hold_ms,       got.outs.hold_ms);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr = '0;
    logic [CFG_D_W-1:0]  cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    pos_t                line_position = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [3:0]          drive_state;
    logic                left_reverse;
    logic                right_reverse;
    logic [DUTY_W-1:0]   left_duty;
    logic [DUTY_W-1:0]   right_duty;
    logic                led_left;
    logic                led_right;
    logic                led_back;
    logic [HOLD_W-1:0]   hold_ms;

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    steering_checker     sb;

    line_follow_steering_fsm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .line_position (line_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_state   (drive_state),
        .left_reverse  (left_reverse),
        .right_reverse (right_reverse),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .led_left      (led_left),
        .led_right     (led_right),
        .led_back      (led_back),
        .hold_ms       (hold_ms)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                sb.check_drive({drive_state, left_reverse, right_reverse, left_duty,
                                right_duty, led_left, led_right, led_back, hold_ms});
            out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    task automatic send_position(input pos_t pos);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        line_position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_position(pos);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_drives.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_D_W-1:0] turn, hard, sharp, speed,
                                input logic [CFG_D_W-1:0] gain_word);
        logic [CFG_A_W-1:0] addrs [6];
        logic [CFG_D_W-1:0] words [6];
        addrs = '{REG_TURN_THR, REG_HARD_THR, REG_SHARP_THR, REG_BASE_SPD, REG_GAIN,
                  REG_SPARE};
        words = '{turn, hard, sharp, speed, gain_word, CFG_D_W'($urandom)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= words[i];
            @(posedge clk);
            sb.set_reg(addrs[i], words[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic pos_t pick_position();
        int          v;
        int          spread;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            v = int'(LOST_CODE);
        else if (r < 35)
        begin
            case ($urandom_range(11))
                0:  v = sb.turn_thr;
                1:  v = sb.turn_thr + 1;
                2:  v = -sb.turn_thr;
                3:  v = -sb.turn_thr - 1;
                4:  v = sb.hard_thr;
                5:  v = sb.hard_thr + 1;
                6:  v = -sb.hard_thr;
                7:  v = -sb.hard_thr - 1;
                8:  v = sb.sharp_thr;
                9:  v = sb.sharp_thr + 1;
                10: v = -sb.sharp_thr;
                default: v = -sb.sharp_thr - 1;
            endcase
        end
        else if (r < 50)
            v = int'($urandom_range(8191)) - 4096;
        else
        begin
            spread = (sb.turn_thr > sb.hard_thr) ? sb.turn_thr : sb.hard_thr;
            spread = (spread > sb.sharp_thr) ? spread : sb.sharp_thr;
            spread = spread + 64;
            if (spread > 4096)
                spread = 4096;
            v = int'($urandom_range(2 * spread)) - spread;
        end
        if (v > 4095)
            v = 4095;
        if (v < -4096)
            v = -4096;
        return pos_t'(v);
    endfunction

    task automatic run_random(input int send_pct, input int recv_pct, input int count);
        int  sent;
        int  mag;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (sent < count)
        begin
            if (!paused && sent >= count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(3) == 0)
            begin
                // A centered start, one turn just past the turn threshold, then the line goes missing.
                if (sb.hard_thr > sb.turn_thr)
                    mag = sb.turn_thr + 1 + int'($urandom_range(sb.hard_thr - sb.turn_thr - 1));
                else
                    mag = sb.turn_thr + 1;
                if (mag > 4095)
                    mag = 4095;
                send_position(pos_t'(0));
                send_position(pos_t'($urandom_range(1) ? mag : -mag));
                sent += 2;
                repeat ($urandom_range(1, 5))
                begin
                    send_position(LOST_CODE);
                    sent++;
                end
            end
            else
            begin
                send_position(pick_position());
                sent++;
            end
        end
        drain_results();
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_POS[i])
            send_position(pos_t'(DIRECTED_POS[i]));
        run_random(0, 0, 200);

        program_regs(12'd0, 12'd0, 12'd0, 12'd10, 12'd0);
        run_random(60, 0, 200);
        program_regs(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd255);
        run_random(0, 60, 100);
        program_regs(12'd300, 12'd100, 12'd50, 12'd5, 12'd3);
        run_random(7, 7, 250);
        program_regs(12'd1000, 12'd1500, 12'd2500, 12'd400, 12'd200);
        run_random(0, 0, 200);
        program_regs(12'd20, 12'd150, 12'd800, 12'd9, 12'hF7F);
        run_random(0, 60, 250);
        program_regs(12'd100, 12'd400, 12'd1200, 12'd2000, 12'd40);
        run_random(60, 0, 250);

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_drives.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lfs_pkg.sv
rtl/core/lfs_next_state.sv
rtl/core/lfs_drive_decode.sv
rtl/core/line_follow_steering_fsm.sv
sim/line_follow_steering_fsm_tb.sv
